[rtl/pps_pkg.sv]
// Package for the polyline point sampler: widths, defaults, register map.
// Used by pps_divider and polyline_point_sampler under rtl; depends on nothing.
`default_nettype none
package pps_pkg;
    localparam int COORD_BITS_DEF  = 12;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int MAX_SAMPLES_DEF = 63;
    localparam int SPACING_BITS    = 8;
    localparam logic [7:0] SPACING_RESET = 8'd5;
    localparam logic [0:0] REG_SAMPLE_SPACING = 1'b0;

    // divider request from the sequencer
    typedef struct packed {
        logic start;
        logic [5:0] den;
    } t_div_req;
endpackage
`default_nettype wire

[rtl/pps_divider.sv]
// Restoring divider, one quotient bit per cycle, shared for x and y offsets.
// Depends on pps_pkg for the request struct.
`default_nettype none
module pps_divider #(
    parameter int NUM_BITS = 26
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pps_pkg::t_div_req   i_req,
    input  wire logic [NUM_BITS-1:0] i_num,
    output logic                     o_done,
    output logic [NUM_BITS-1:0]      o_quot
);
    localparam int CW = $clog2(NUM_BITS + 1);
    logic [NUM_BITS-1:0] r_q;
    logic [6:0]          r_rem;
    logic [5:0]          r_den;
    logic [CW-1:0]       r_cnt;
    logic                r_busy;
    logic [6:0]          w_trial;

    assign w_trial = {r_rem[5:0], r_q[NUM_BITS-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_req.den;
                r_cnt  <= CW'(NUM_BITS);
            end else if (r_busy) begin
                if (w_trial >= {1'b0, r_den}) begin
                    r_rem <= w_trial - {1'b0, r_den};
                    r_q   <= {r_q[NUM_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[NUM_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_q;
endmodule
`default_nettype wire

[rtl/polyline_point_sampler.sv]
// Top level of the polyline point sampler: APB register, sequencer, shared
// multiplier and divider. Depends on pps_pkg and pps_divider.
//
// Each key point is taken while o_in_ready is high; the block then stays busy.
// It searches the segment count in steps that each multiply count+1 by
// spacing and then square the product, up to MAX_SAMPLES+1 steps; then
// for each sample it runs the serial divider twice (x and y) and hands the
// sample to a one-entry output register. The final point adds one output.
`default_nettype none
module polyline_point_sampler #(
    parameter int COORD_BITS  = pps_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS   = pps_pkg::FRAC_BITS_DEF,
    parameter int MAX_SAMPLES = pps_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [2:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [COORD_BITS-1:0]     i_point_x,
    input  wire logic [COORD_BITS-1:0]     i_point_y,
    input  wire logic                      i_path_end,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [COORD_BITS+FRAC_BITS-1:0] o_sample_x,
    output logic [COORD_BITS+FRAC_BITS-1:0] o_sample_y,
    output logic                           o_final_sample
);
    localparam int OB = COORD_BITS + FRAC_BITS;
    localparam int DIV_BITS = COORD_BITS + 6 + FRAC_BITS;
    localparam int D2B = 2 * COORD_BITS + 1;
    localparam int LB = 6 + pps_pkg::SPACING_BITS;
    localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_SQ = 3'd2,
                           S_DX = 3'd3, S_DY = 3'd4, S_OUT = 3'd5, S_FIN = 3'd6;

    logic [2:0] r_st;
    logic [7:0] r_spacing;
    logic [COORD_BITS-1:0] r_px, r_py, r_qx, r_qy;
    logic r_hold, r_last;
    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic r_negx, r_negy;
    logic [D2B-1:0] r_d2;
    logic [5:0] r_n, r_j;
    logic [LB-1:0] r_len;
    logic [OB-1:0] r_ox;
    logic [DIV_BITS-1:0] w_num;
    logic [DIV_BITS-1:0] w_quot;
    logic w_done;
    pps_pkg::t_div_req w_req;
    logic [2*LB-1:0] w_sq;
    logic [COORD_BITS-1:0] w_dsel;
    logic [COORD_BITS+5:0] w_prod;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == pps_pkg::REG_SAMPLE_SPACING)
        ? {24'd0, r_spacing} : 32'd0;
    assign o_in_ready = (r_st == S_IDLE) && !o_out_valid;
    assign w_sq = r_len * r_len;
    assign w_dsel = (r_st == S_DX) ? r_dx : r_dy;
    assign w_prod = {6'd0, w_dsel} * {{COORD_BITS{1'b0}}, r_j};

    always_comb begin
        w_req.den = r_n;
        w_req.start = 1'b0;
        w_num = '0;
        if (r_st == S_DX || r_st == S_DY) begin
            w_num = {w_prod, {FRAC_BITS{1'b0}}};
        end
    end

    // divider start (r_kick) is registered together with the move into a divide state
    logic r_kick;
    pps_pkg::t_div_req w_req2;
    always_comb begin
        w_req2 = w_req;
        w_req2.start = r_kick;
    end

    pps_divider #(.NUM_BITS(DIV_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req2), .i_num(w_num),
        .o_done(w_done), .o_quot(w_quot)
    );

    function automatic logic [OB-1:0] f_apply(input logic [COORD_BITS-1:0] p,
                                              input logic neg,
                                              input logic [DIV_BITS-1:0] q);
        logic [OB-1:0] b;
        b = {p, {FRAC_BITS{1'b0}}};
        return neg ? b - OB'(q) : b + OB'(q);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_spacing <= pps_pkg::SPACING_RESET;
            r_hold <= 1'b0;
            r_px <= '0;
            r_py <= '0;
            o_out_valid <= 1'b0;
            r_kick <= 1'b0;
        end else begin
            r_kick <= 1'b0;
            if (psel && penable && pwrite &&
                paddr[2] == pps_pkg::REG_SAMPLE_SPACING)
                r_spacing <= pwdata[7:0];
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_qx <= i_point_x;
                        r_qy <= i_point_y;
                        r_last <= i_path_end;
                        r_negx <= i_point_x < r_px;
                        r_negy <= i_point_y < r_py;
                        r_dx <= (i_point_x < r_px) ? r_px - i_point_x : i_point_x - r_px;
                        r_dy <= (i_point_y < r_py) ? r_py - i_point_y : i_point_y - r_py;
                        r_n <= '0;
                        r_j <= '0;
                        r_st <= r_hold ? S_MUL : S_FIN;
                    end
                end
                S_MUL: begin
                    r_d2 <= D2B'(r_dx * r_dx) + D2B'(r_dy * r_dy);
                    r_len <= LB'((r_n + 1'b1) * r_spacing);
                    r_st <= S_SQ;
                end
                S_SQ: begin
                    if (r_n == 6'(MAX_SAMPLES) || w_sq > (2*LB)'(r_d2)) begin
                        if (r_n == 0) r_st <= S_FIN;
                        else begin
                            r_st <= S_DX;
                            r_kick <= 1'b1;
                        end
                    end else begin
                        r_n <= r_n + 1'b1;
                        r_st <= S_MUL;
                    end
                end
                S_DX: if (w_done) begin
                    r_ox <= f_apply(r_px, r_negx, w_quot);
                    r_st <= S_DY;
                    r_kick <= 1'b1;
                end
                S_DY: if (w_done) r_st <= S_OUT;
                S_OUT: if (!o_out_valid) begin
                    o_out_valid <= 1'b1;
                    o_sample_x <= r_ox;
                    o_sample_y <= f_apply(r_py, r_negy, w_quot);
                    o_final_sample <= 1'b0;
                    r_j <= r_j + 1'b1;
                    if (r_j + 1'b1 == r_n) r_st <= S_FIN;
                    else begin
                        r_st <= S_DX;
                        r_kick <= 1'b1;
                    end
                end
                S_FIN: if (!o_out_valid) begin
                    if (r_last) begin
                        o_out_valid <= 1'b1;
                        o_sample_x <= {r_qx, {FRAC_BITS{1'b0}}};
                        o_sample_y <= {r_qy, {FRAC_BITS{1'b0}}};
                        o_final_sample <= 1'b1;
                        r_px <= '0;
                        r_py <= '0;
                        r_hold <= 1'b0;
                    end else begin
                        r_px <= r_qx;
                        r_py <= r_qy;
                        r_hold <= 1'b1;
                    end
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/pps_checker.sv]
// Port-level checks for the polyline point sampler, bound to the top level.
// Depends on polyline_point_sampler ports only.
`default_nettype none
module pps_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire logic o_final_sample,
    input wire logic [19:0] o_sample_x
);
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready) else $error("ready after accept");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_sample_x) && $stable(o_final_sample)))
        else $error("output dropped");
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("ready with pending output");
endmodule
bind polyline_point_sampler pps_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
    .o_final_sample(o_final_sample), .o_sample_x(o_sample_x)
);
`default_nettype wire

[dv/polyline_point_sampler_tb.sv]
// Testbench for polyline_point_sampler: feeds key points, predicts the resampled
// points in a local model and checks every output item. Depends on pps_pkg.
`default_nettype none
module polyline_point_sampler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB       = pps_pkg::COORD_BITS_DEF;
    localparam int FB       = pps_pkg::FRAC_BITS_DEF;
    localparam int OB       = CB + FB;
    localparam int MAXS     = pps_pkg::MAX_SAMPLES_DEF;
    localparam int SETTLE   = 400;
    localparam longint unsigned CYCLE_LIMIT = 6000000;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          last;
    } t_key_point;

    typedef struct packed {
        logic [OB-1:0] x;
        logic [OB-1:0] y;
        logic          fin;
    } t_sample;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [2:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;
    logic           i_in_valid = 1'b0;
    logic           o_in_ready;
    logic [CB-1:0]  i_point_x = '0;
    logic [CB-1:0]  i_point_y = '0;
    logic           i_path_end = 1'b0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    logic [OB-1:0]  o_sample_x;
    logic [OB-1:0]  o_sample_y;
    logic           o_final_sample;

    polyline_point_sampler u_dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_in_valid, .o_in_ready, .i_point_x, .i_point_y, .i_path_end,
        .o_out_valid, .i_out_ready, .o_sample_x, .o_sample_y, .o_final_sample
    );

    always #5 i_clk = ~i_clk;

    // local copy of the block's state
    logic [7:0]     spacing = pps_pkg::SPACING_RESET;
    logic [CB-1:0]  held_x = '0;
    logic [CB-1:0]  held_y = '0;
    logic           holding = 1'b0;

    t_key_point     pending_points[$];
    t_sample        expected_samples[$];
    int             mismatches = 0;
    int             accepted_points = 0;
    int             in_gap = 0;
    int             out_stall = 0;
    longint unsigned cycles = 0;

    function automatic logic [OB-1:0] lerp_coord(logic [CB-1:0] p, logic [CB-1:0] q,
                                                 int j, int num);
        longint unsigned base;
        longint unsigned off;
        base = longint'(p) << FB;
        if (q >= p) begin
            off = ((longint'(q - p) * j) << FB) / num;
            return OB'(base + off);
        end
        off = ((longint'(p - q) * j) << FB) / num;
        return OB'(base - off);
    endfunction

    function automatic int count_segments(logic [CB-1:0] px, logic [CB-1:0] py,
                                          logic [CB-1:0] qx, logic [CB-1:0] qy);
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned d2;
        longint unsigned len;
        int n;
        dx = (qx >= px) ? qx - px : px - qx;
        dy = (qy >= py) ? qy - py : py - qy;
        d2 = dx * dx + dy * dy;
        n = 0;
        while (n < MAXS) begin
            len = longint'(n + 1) * spacing;
            if (len * len > d2) break;
            n++;
        end
        return n;
    endfunction

    task automatic predict_samples(t_key_point kp);
        int num;
        t_sample s;
        if (holding) begin
            num = count_segments(held_x, held_y, kp.x, kp.y);
            for (int j = 0; j < num; j++) begin
                s.x = lerp_coord(held_x, kp.x, j, num);
                s.y = lerp_coord(held_y, kp.y, j, num);
                s.fin = 1'b0;
                expected_samples = {expected_samples, s};
            end
        end
        if (kp.last) begin
            s.x = OB'(kp.x) << FB;
            s.y = OB'(kp.y) << FB;
            s.fin = 1'b1;
            expected_samples = {expected_samples, s};
            held_x = '0;
            held_y = '0;
            holding = 1'b0;
        end else begin
            held_x = kp.x;
            held_y = kp.y;
            holding = 1'b1;
        end
    endtask

    // input driver: bursts without gaps every third block of 30 items
    always @(posedge i_clk) begin
        t_key_point kp;
        logic next_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                predict_samples({i_point_x, i_point_y, i_path_end});
                accepted_points++;
                next_valid = 1'b0;
                in_gap = ((accepted_points / 30) % 3 == 0) ? 0 : $urandom_range(0, 17);
            end
            if (!next_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_points.size() > 0) begin
                    kp = pending_points.pop_front();
                    i_point_x <= kp.x;
                    i_point_y <= kp.y;
                    i_path_end <= kp.last;
                    next_valid = 1'b1;
                end
            end
            i_in_valid <= next_valid;
        end
    end

    // output monitor and ready stalls
    always @(posedge i_clk) begin
        t_sample exp_s;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item x=%h y=%h final=%b",
                                 o_sample_x, o_sample_y, o_final_sample);
                end else begin
                    exp_s = expected_samples.pop_front();
                    if (exp_s.x !== o_sample_x || exp_s.y !== o_sample_y ||
                        exp_s.fin !== o_final_sample) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp x=%h y=%h f=%b, got x=%h y=%h f=%b",
                                     exp_s.x, exp_s.y, exp_s.fin,
                                     o_sample_x, o_sample_y, o_final_sample);
                    end
                end
                out_stall = ((accepted_points / 30) % 3 == 1) ? 0 : $urandom_range(0, 17);
            end
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_spacing(logic [7:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {pps_pkg::REG_SAMPLE_SPACING, 2'b00};
        pwdata <= {24'($urandom_range(0, 16777215)), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        spacing = value;
    endtask

    task automatic push_point(int x, int y, bit last);
        t_key_point kp;
        kp.x = CB'(x);
        kp.y = CB'(y);
        kp.last = last;
        pending_points = {pending_points, kp};
    endtask

    // wait for all items to drain, then give the block time to finish a silent item
    task automatic drain();
        while (pending_points.size() > 0 || i_in_valid || expected_samples.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // random walk: mostly short hops scaled by spacing, some jumps anywhere
    task automatic random_paths(int n);
        int cx;
        int cy;
        int reach;
        cx = $urandom_range(0, 4095);
        cy = $urandom_range(0, 4095);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                cx = $urandom_range(0, 4095);
                cy = $urandom_range(0, 4095);
            end else begin
                reach = (spacing == 0 ? 1 : spacing) * $urandom_range(0, 10);
                cx += $urandom_range(0, 2 * reach) - reach;
                cy += $urandom_range(0, 2 * reach) - reach;
                cx = cx < 0 ? 0 : (cx > 4095 ? 4095 : cx);
                cy = cy < 0 ? 0 : (cy > 4095 ? 4095 : cy);
            end
            push_point(cx, cy, $urandom_range(0, 7) == 0);
        end
        drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset spacing: first point, long saturated segment, zero length, final
        push_point(0, 0, 0);
        push_point(4095, 4095, 0);
        push_point(4095, 4095, 0);
        push_point(0, 4095, 0);
        push_point(4095, 0, 1);
        push_point(2048, 17, 1);
        push_point(10, 10, 0);
        push_point(13, 14, 0);
        push_point(3, 2, 1);
        drain();

        write_spacing(8'd255);
        push_point(4095, 0, 0);
        push_point(0, 4095, 0);
        push_point(100, 100, 1);
        drain();

        write_spacing(8'd1);
        push_point(2730, 1365, 0);
        push_point(2737, 1360, 0);
        push_point(2737, 1360, 1);
        drain();

        // spacing of zero saturates even on a zero-length segment
        write_spacing(8'd0);
        push_point(7, 9, 0);
        push_point(7, 9, 0);
        push_point(0, 0, 1);
        drain();

        write_spacing(8'd5);
        random_paths(60);
        write_spacing(8'd1);
        random_paths(30);
        write_spacing(8'd255);
        random_paths(40);
        write_spacing(8'($urandom_range(2, 254)));
        random_paths(60);
        write_spacing(8'($urandom_range(2, 40)));
        random_paths(60);

        if (mismatches == 0 && expected_samples.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
